// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the keyed status table.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define KSRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define KSRT_NEVER(lbl, clk, rst_n, cond) \
  `KSRT_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: hdl/ksrt_pkg.sv
// Package of the keyed status table: action and status codes and the
// broadcast update type. No dependencies.
package ksrt_pkg;

  localparam int unsigned ActionBits = 3;
  localparam int unsigned IdBits     = 32;

  localparam logic [ActionBits-1:0] ACT_INSERT     = 3'd0;
  localparam logic [ActionBits-1:0] ACT_INSERT_ROS = 3'd1;
  localparam logic [ActionBits-1:0] ACT_COPY_CHECK = 3'd2;
  localparam logic [ActionBits-1:0] ACT_DEFER_DEL  = 3'd3;
  localparam logic [ActionBits-1:0] ACT_DEL_CHECK  = 3'd4;
  localparam logic [ActionBits-1:0] ACT_REMOVE_IF  = 3'd5;

  localparam logic [1:0] ST_NOT_SAVED = 2'd0;
  localparam logic [1:0] ST_REMOVE_ON_SAVE = 2'd1;
  localparam logic [1:0] ST_SAVED = 2'd2;
  localparam logic [1:0] ST_DELETED = 2'd3;

  // Update broadcast to every cell while busy_o is high, after the key compare.
  typedef struct packed {
    logic       insert;     // granted free cell takes the key
    logic       set_status; // matching cell takes new_status
    logic       remove;     // matching cell is freed
    logic [1:0] new_status;
  } upd_t;

endpackage

// File: hdl/ksrt_cell.sv
// One entry of the keyed status table: valid bit, key, status, match and
// free-slot grant. Depends on ksrt_pkg.
module ksrt_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                look_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                free_left_i,
  output logic                free_left_o,
  input  ksrt_pkg::upd_t      upd_i,
  input  logic                apply_i,
  output logic                hit_o,
  output logic                grant_o,
  output logic [1:0]          status_o
);

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]          status_q;
  logic                hit_q, grant_q;

  // The free chain: a free cell is granted only if no cell to its left is free.
  assign free_left_o = free_left_i | ~valid_q;

  always_comb begin
    valid_d = valid_q;
    if (apply_i && hit_q && upd_i.remove) begin
      valid_d = 1'b0;
    end
    if (apply_i && grant_q && upd_i.insert) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      grant_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (look_i) begin
        hit_q   <= valid_q && (key_q == key_i);
        grant_q <= ~valid_q & ~free_left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_i && grant_q && upd_i.insert) begin
      key_q    <= key_i;
      status_q <= upd_i.new_status;
    end else if (apply_i && hit_q && upd_i.set_status) begin
      status_q <= upd_i.new_status;
    end
  end

  assign hit_o    = hit_q;
  assign grant_o  = grant_q;
  assign status_o = hit_q ? status_q : 2'b00;

endmodule

// File: hdl/keyed_status_reference_table_unit.sv
// Top level of the keyed status table: a row of ksrt_cell entries plus the
// decision logic. Depends on ksrt_pkg, ksrt_cell and assert_macros.svh.
//
//  port group       direction  handshake
//  command          in         start_i, busy_o; action_i, object_id_i
//  result           out        done_o strobe; answer_o, found_o,
//                              table_full_o, odd_status_o
//
// In a transaction, the cycle of acceptance compares the key in every cell
// and ripples the free-slot chain, and the next cycle (busy_o high) decides
// and updates the cells. The result appears for one cycle after that, when
// a new transaction can already be accepted. Reset empties the table at
// once. The receiver cannot stall the result.
`include "assert_macros.svh"

module keyed_status_reference_table_unit #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ksrt_pkg::ActionBits-1:0]     action_i,
  input  logic [ksrt_pkg::IdBits-1:0]         object_id_i,
  output logic                                done_o,
  output logic                                answer_o,
  output logic                                found_o,
  output logic                                table_full_o,
  output logic                                odd_status_o
);

  logic                              busy_q;
  logic                              look;
  logic [ksrt_pkg::ActionBits-1:0]   action_q;
  logic [KEY_BITS-1:0]               key_in, key_q, key_cell;
  logic [ENTRIES:0]                  free_left;
  logic [ENTRIES-1:0]                hit_vec, grant_vec;
  logic [1:0]                        status_vec [ENTRIES];
  logic [1:0]                        st;
  logic                              found, any_grant;
  ksrt_pkg::upd_t                    upd;
  logic                              ans_d, full_d, odd_d;
  logic                              done_q, answer_q, found_q, full_q, odd_q;

  assign look = start_i & ~busy_q;

  if (KEY_BITS <= ksrt_pkg::IdBits) begin : g_key_narrow
    assign key_in = object_id_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign key_in = {{(KEY_BITS - ksrt_pkg::IdBits){1'b0}}, object_id_i};
  end

  // Cells compare against the port key on acceptance and store it on update.
  assign key_cell = busy_q ? key_q : key_in;

  assign free_left[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ksrt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .look_i     (look),
      .key_i      (key_cell),
      .free_left_i(free_left[i]),
      .free_left_o(free_left[i+1]),
      .upd_i      (upd),
      .apply_i    (busy_q),
      .hit_o      (hit_vec[i]),
      .grant_o    (grant_vec[i]),
      .status_o   (status_vec[i])
    );
  end

  always_comb begin
    st = 2'b00;
    for (int i = 0; i < ENTRIES; i++) begin
      st = st | status_vec[i];
    end
  end

  assign found     = |hit_vec;
  assign any_grant = |grant_vec;

  always_comb begin
    upd    = '0;
    ans_d  = 1'b0;
    full_d = 1'b0;
    odd_d  = 1'b0;
    case (action_q)
      ksrt_pkg::ACT_INSERT, ksrt_pkg::ACT_INSERT_ROS: begin
        if (found) begin
          odd_d = 1'b1;
        end else if (!any_grant) begin
          full_d = 1'b1;
        end else begin
          upd.insert     = 1'b1;
          upd.new_status = (action_q == ksrt_pkg::ACT_INSERT) ?
                           ksrt_pkg::ST_NOT_SAVED : ksrt_pkg::ST_REMOVE_ON_SAVE;
        end
      end
      ksrt_pkg::ACT_COPY_CHECK: begin
        ans_d = 1'b1;
        if (found && st == ksrt_pkg::ST_NOT_SAVED) begin
          upd.set_status = 1'b1;
          upd.new_status = ksrt_pkg::ST_SAVED;
          ans_d          = 1'b0;
        end else if (found && st == ksrt_pkg::ST_REMOVE_ON_SAVE) begin
          upd.remove = 1'b1;
          ans_d      = 1'b0;
        end
      end
      ksrt_pkg::ACT_DEFER_DEL: begin
        if (found) begin
          ans_d          = 1'b1;
          odd_d          = (st != ksrt_pkg::ST_SAVED);
          upd.set_status = 1'b1;
          upd.new_status = ksrt_pkg::ST_DELETED;
        end
      end
      ksrt_pkg::ACT_DEL_CHECK: begin
        if (found) begin
          ans_d      = (st != ksrt_pkg::ST_SAVED);
          odd_d      = (st == ksrt_pkg::ST_REMOVE_ON_SAVE);
          upd.remove = 1'b1;
        end
      end
      ksrt_pkg::ACT_REMOVE_IF: begin
        if (found) begin
          ans_d      = 1'b1;
          upd.remove = 1'b1;
        end
      end
      default: begin
        upd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= look;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look) begin
      action_q <= action_i;
      key_q    <= key_in;
    end
    if (busy_q) begin
      answer_q <= ans_d;
      found_q  <= found;
      full_q   <= full_d;
      odd_q    <= odd_d;
    end
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign answer_o     = answer_q;
  assign found_o      = found_q;
  assign table_full_o = full_q;
  assign odd_status_o = odd_q;

  `KSRT_ASSERT(a_busy_then_done, clk_i, rst_ni, busy_q |=> done_q && !busy_q)
  `KSRT_ASSERT(a_hit_onehot, clk_i, rst_ni, busy_q |-> $onehot0(hit_vec))
  `KSRT_ASSERT(a_grant_onehot, clk_i, rst_ni, busy_q |-> $onehot0(grant_vec))
  `KSRT_NEVER(a_full_and_found, clk_i, rst_ni, done_q && full_q && found_q)

endmodule
